>>> rtl/rcl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the rotary code lock controller.
// No dependencies; used by rcl_code_store and rotary_code_lock_controller.
package rcl_pkg;

	localparam int          DIGIT_W    = 4;
	localparam int          POS_W      = 3;
	localparam int          HOLD_W     = 16;
	localparam int          IN_W       = 8;
	localparam int          OUT_W      = 24;
	localparam int          RES_W      = 17;

	localparam logic [DIGIT_W-1:0] SEL_BACK   = 4'd10;
	localparam logic [DIGIT_W-1:0] DIGIT_ONE  = 4'd1;
	localparam logic [HOLD_W-1:0]  HOLD_RESET = 16'd900;
	localparam logic [HOLD_W-1:0]  HOLD_MAX   = 16'hFFFF;

	typedef enum logic [2:0] {
		MODE_LOCKED   = 3'd0,
		MODE_ENTER    = 3'd1,
		MODE_NEW      = 3'd2,
		MODE_CONFIRM  = 3'd3,
		MODE_UNLOCKED = 3'd4,
		MODE_HOLDING  = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		EVT_NONE     = 3'd0,
		EVT_ACCEPTED = 3'd1,
		EVT_REJECTED = 3'd2,
		EVT_CHANGED  = 3'd3,
		EVT_FAILED   = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		CLICK_NONE   = 2'd0,
		CLICK_UP     = 2'd1,
		CLICK_DOWN   = 2'd2,
		CLICK_BUTTON = 2'd3
	} click_t;

	typedef struct packed {
		logic               wr_en;
		logic [POS_W-1:0]   wr_pos;
		logic [DIGIT_W-1:0] wr_digit;
		logic               save_first;
		logic               commit;
		logic               fire;
	} store_ctl_t;

	typedef struct packed {
		logic match_stored;
		logic match_first;
	} store_sts_t;

	typedef struct packed {
		logic [1:0]         click;
		logic [2:0]         event_res;
		logic [POS_W-1:0]   digits_entered;
		logic [DIGIT_W-1:0] selected_digit;
		logic               unlock_drive;
		logic               secure_led;
		logic [2:0]         mode;
	} result_t;

endpackage

>>> rtl/rcl_code_store.sv
`timescale 1ns / 1ps
// Digit stores for the code lock: entry buffer, first new code and stored code,
// with the code comparators. Depends on rcl_pkg.
module rcl_code_store #(
	parameter int CODE_DIGITS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rcl_pkg::store_ctl_t ctl,
	output rcl_pkg::store_sts_t sts
);

	localparam int IdxW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

	logic [rcl_pkg::DIGIT_W-1:0] entry_q  [CODE_DIGITS];
	logic [rcl_pkg::DIGIT_W-1:0] entry_n  [CODE_DIGITS];
	logic [rcl_pkg::DIGIT_W-1:0] first_q  [CODE_DIGITS];
	logic [rcl_pkg::DIGIT_W-1:0] stored_q [CODE_DIGITS];
	logic [IdxW-1:0]             wr_idx;

	assign wr_idx = ctl.wr_pos[IdxW-1:0];

	always_comb begin
		sts.match_stored = 1'b1;
		sts.match_first  = 1'b1;
		for (int i = 0; i < CODE_DIGITS; i++) begin
			entry_n[i] = (ctl.wr_en && wr_idx == IdxW'(i)) ? ctl.wr_digit : entry_q[i];
			if (entry_n[i] != stored_q[i]) begin
				sts.match_stored = 1'b0;
			end
			if (entry_n[i] != first_q[i]) begin
				sts.match_first = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire && ctl.wr_en) begin
			entry_q[wr_idx] <= ctl.wr_digit;
		end
		if (ctl.fire && ctl.save_first) begin
			first_q <= entry_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CODE_DIGITS; i++) begin
				stored_q[i] <= (i < 2) ? rcl_pkg::DIGIT_ONE : '0;
			end
		end else if (ctl.fire && ctl.commit) begin
			stored_q <= first_q;
		end
	end

endmodule

>>> rtl/rotary_code_lock_controller.sv
`timescale 1ns / 1ps
// Rotary encoder code lock controller: input stage, lock state machine, result stage.
// Depends on rcl_pkg and rcl_code_store.
//
//  channel  | dir | handshake                     | payload
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | enc_a, enc_b, button
//  m_axis   | out | m_axis_tvalid / m_axis_tready | mode .. click
//  cfg      | in  | cfg_valid / cfg_ready         | hold_ticks
//
// One transaction per cycle while m_axis_tready is high; a result is valid once its input
// has passed the input register and then the state update into the result register.
// The state machine and digit stores advance only when the result register is free
// or drained, so a stalled output holds the input stage and then s_axis_tready.
// arst_n clears all control state and loads the default code and hold_ticks = 900.
module rotary_code_lock_controller #(
	parameter int CODE_DIGITS = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [rcl_pkg::IN_W-1:0]   s_axis_tdata,  // enc_a, enc_b, button
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [rcl_pkg::OUT_W-1:0]  m_axis_tdata,  // mode[3], secure_led, unlock_drive,
	                                                  // selected_digit[4], digits_entered[3],
	                                                  // event_res[3], click[2]
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [rcl_pkg::HOLD_W-1:0] cfg_data
);

	localparam logic [rcl_pkg::POS_W:0] NumDigits = (rcl_pkg::POS_W + 1)'(CODE_DIGITS);

	logic                          in_valid_s1;
	logic                          enc_a_s1;
	logic                          enc_b_s1;
	logic                          button_s1;
	logic                          advance;

	rcl_pkg::mode_t                mode_q, mode_n;
	logic                          change_pending_q, pend_n;
	logic                          last_a_q;
	logic                          last_btn_q;
	logic [rcl_pkg::DIGIT_W-1:0]   sel_q, sel_n;
	logic [rcl_pkg::POS_W-1:0]     pos_q, pos_n;
	logic [rcl_pkg::POS_W:0]       pos_step;
	logic [rcl_pkg::HOLD_W-1:0]    hold_count_q, hold_n;
	logic [rcl_pkg::HOLD_W-1:0]    hold_ticks_q;

	logic                          a_rise;
	logic                          btn_rise;
	logic                          btn_fall;
	rcl_pkg::event_t               evt;
	rcl_pkg::click_t               cue;
	rcl_pkg::store_ctl_t           ctl;
	rcl_pkg::store_sts_t           sts;
	rcl_pkg::result_t              res_n;
	rcl_pkg::result_t              result_q;
	logic                          out_valid_q;

	assign advance       = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(rcl_pkg::OUT_W - rcl_pkg::RES_W)'(0), result_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			enc_a_s1  <= s_axis_tdata[0];
			enc_b_s1  <= s_axis_tdata[1];
			button_s1 <= s_axis_tdata[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= rcl_pkg::HOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			hold_ticks_q <= cfg_data;
		end
	end

	rcl_code_store #(
		.CODE_DIGITS(CODE_DIGITS)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.sts   (sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q           <= rcl_pkg::MODE_LOCKED;
			change_pending_q <= 1'b0;
			last_a_q         <= 1'b0;
			last_btn_q       <= 1'b0;
			sel_q            <= '0;
			pos_q            <= '0;
			hold_count_q     <= '0;
		end else if (advance) begin
			mode_q           <= mode_n;
			change_pending_q <= pend_n;
			last_a_q         <= enc_a_s1;
			last_btn_q       <= button_s1;
			sel_q            <= sel_n;
			pos_q            <= pos_n;
			hold_count_q     <= hold_n;
		end
	end

	always_comb begin
		a_rise     = enc_a_s1 && !last_a_q;
		btn_rise   = button_s1 && !last_btn_q;
		btn_fall   = !button_s1 && last_btn_q;
		mode_n     = mode_q;
		pend_n     = change_pending_q;
		sel_n      = sel_q;
		pos_n      = pos_q;
		pos_step   = {1'b0, pos_q};
		hold_n     = hold_count_q;
		evt        = rcl_pkg::EVT_NONE;
		cue        = rcl_pkg::CLICK_NONE;
		ctl        = '0;
		ctl.fire   = advance;
		ctl.wr_pos = pos_q;

		case (mode_q)
			rcl_pkg::MODE_ENTER, rcl_pkg::MODE_NEW, rcl_pkg::MODE_CONFIRM: begin
				if (a_rise) begin
					if (enc_b_s1) begin
						sel_n = (sel_q >= rcl_pkg::SEL_BACK) ? '0 : sel_q + 4'd1;
						cue   = rcl_pkg::CLICK_UP;
					end else begin
						sel_n = (sel_q == '0 || sel_q > rcl_pkg::SEL_BACK) ?
						        rcl_pkg::SEL_BACK : sel_q - 4'd1;
						cue   = rcl_pkg::CLICK_DOWN;
					end
				end
				ctl.wr_digit = sel_n;
				if (btn_fall) begin
					if (sel_n == rcl_pkg::SEL_BACK) begin
						if (pos_q != '0) begin
							pos_step = {1'b0, pos_q} - 1'b1;
						end
					end else if ({1'b0, pos_q} < NumDigits) begin
						ctl.wr_en = 1'b1;
						pos_step  = {1'b0, pos_q} + 1'b1;
					end
					if (pos_step >= NumDigits) begin
						pos_n = '0;
						if (mode_q == rcl_pkg::MODE_ENTER) begin
							if (sts.match_stored) begin
								evt    = rcl_pkg::EVT_ACCEPTED;
								pend_n = 1'b0;
								mode_n = change_pending_q ? rcl_pkg::MODE_NEW :
								         rcl_pkg::MODE_UNLOCKED;
							end else begin
								evt    = rcl_pkg::EVT_REJECTED;
								pend_n = 1'b0;
								mode_n = rcl_pkg::MODE_LOCKED;
							end
						end else if (mode_q == rcl_pkg::MODE_NEW) begin
							ctl.save_first = 1'b1;
							mode_n         = rcl_pkg::MODE_CONFIRM;
						end else begin
							if (sts.match_first) begin
								ctl.commit = 1'b1;
								evt        = rcl_pkg::EVT_CHANGED;
							end else begin
								evt        = rcl_pkg::EVT_FAILED;
							end
							mode_n = rcl_pkg::MODE_LOCKED;
						end
					end else begin
						pos_n = pos_step[rcl_pkg::POS_W-1:0];
					end
				end
			end
			rcl_pkg::MODE_UNLOCKED: begin
				if (button_s1) begin
					hold_n = '0;
					mode_n = rcl_pkg::MODE_HOLDING;
				end
			end
			rcl_pkg::MODE_HOLDING: begin
				if (button_s1) begin
					if (hold_count_q != rcl_pkg::HOLD_MAX) begin
						hold_n = hold_count_q + 1'b1;
					end
				end else if (hold_count_q >= hold_ticks_q) begin
					pend_n = 1'b1;
					pos_n  = '0;
					mode_n = rcl_pkg::MODE_ENTER;
				end else begin
					mode_n = rcl_pkg::MODE_LOCKED;
				end
			end
			default: begin
				mode_n = rcl_pkg::MODE_LOCKED;
				if (btn_fall) begin
					pos_n  = '0;
					mode_n = rcl_pkg::MODE_ENTER;
				end
			end
		endcase

		if (btn_rise) begin
			cue = rcl_pkg::CLICK_BUTTON;
		end

		res_n.mode           = mode_n;
		res_n.secure_led     = (mode_n <= rcl_pkg::MODE_CONFIRM);
		res_n.unlock_drive   = (mode_n >= rcl_pkg::MODE_UNLOCKED);
		res_n.selected_digit = sel_n;
		res_n.digits_entered = pos_n;
		res_n.event_res      = evt;
		res_n.click          = cue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res_n;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} < NumDigits)
		else $error("entry position out of range");

	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q <= rcl_pkg::SEL_BACK)
		else $error("selector out of range");

	a_accept_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.event_res == rcl_pkg::EVT_ACCEPTED) |->
		(result_q.mode == rcl_pkg::MODE_UNLOCKED || result_q.mode == rcl_pkg::MODE_NEW))
		else $error("accepted code without unlock or change");

	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (out_valid_q && result_q.mode == $past(mode_n)))
		else $error("result not registered after advance");

endmodule
